FILE: design/assert_macros.svh
// Assertion macros used by the checker file of this block, gsff_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSFF_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gsff assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GSFF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gsff assertion failed");

// A check that is not masked by reset.
`define GSFF_ASSERT_ALWAYS(lbl, clk, pre, post) \
   lbl: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error("gsff assertion failed");

`endif

FILE: design/gsff_pkg.sv
// Package of the Gaussian-sum form factor block: widths, constants, types and
// the reciprocal tables of the exponential series. Depends on nothing.
`default_nettype none

package gsff_pkg;

   localparam int MaxTerms  = 5;
   localparam int XW        = 24;
   localparam int SqW       = 28;
   localparam int CoefW     = 32;
   localparam int PairW     = 2 * CoefW;
   localparam int TW        = CoefW + SqW;
   localparam int RemW      = 38;
   localparam int KW        = 6;
   localparam int DivBits   = 2;
   localparam int DivStages = KW / DivBits;
   localparam int RW        = 32;
   localparam int PW        = 33;
   localparam int NW        = 4;
   localparam int ShW       = 6;
   localparam int HornerDeg = 12;
   localparam int FfW       = 32;
   localparam int SumW      = 35;
   localparam int CntW      = 3;
   localparam int IdxW      = 3;
   localparam int LaneLat   = 2 + DivStages + 2 * HornerDeg + 2;
   localparam int PipeDepth = 1 + LaneLat + 3;

   localparam logic [RW-1:0] LnTwo  = 32'hB17217F8;
   localparam logic [PW-1:0] OneQ32 = {1'b1, {RW{1'b0}}};
   localparam logic [TW-1:0] ExpCut = TW'(23) << 40;

   typedef enum logic [IdxW-1:0] {
      CsrTermCount = 3'd0,
      CsrPair0     = 3'd1,
      CsrOffset    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CntW-1:0]                  n_terms;
      logic [MaxTerms-1:0][CoefW-1:0]   a;
      logic [MaxTerms-1:0][CoefW-1:0]   b;
      logic [CoefW-1:0]                 c;
   } cfg_type;

   typedef struct packed {
      logic          cut;
      logic [KW-1:0] k;
      logic [RW-1:0] r;
      logic [PW-1:0] p;
   } lane_bus_type;

   // Rounded-up reciprocal so that floor(m * recip >> shift) == m / n for
   // every 32-bit m.
   function automatic logic [PW-1:0] recip_of(input logic [NW-1:0] n);
      logic [PW-1:0] v;
      unique case (n)
         4'd3, 4'd6, 4'd12: v = 33'h1_5555_5556;
         4'd5, 4'd10:       v = 33'h1_9999_999A;
         4'd7:              v = 33'h1_2492_4925;
         4'd9:              v = 33'h1_C71C_71C8;
         4'd11:             v = 33'h1_745D_1746;
         default:           v = OneQ32;
      endcase
      return v;
   endfunction

   function automatic logic [ShW-1:0] shift_of(input logic [NW-1:0] n);
      logic [ShW-1:0] v;
      unique case (n)
         4'd0, 4'd1:               v = 6'd32;
         4'd2:                     v = 6'd33;
         4'd3, 4'd4:               v = 6'd34;
         4'd5, 4'd6, 4'd7, 4'd8:   v = 6'd35;
         default:                  v = 6'd36;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: design/gsff_req_if.sv
// Input channel of the form factor block: valid, ready and one x item.
// Depends on gsff_pkg.
`default_nettype none

interface gsff_req_if
   import gsff_pkg::*;
();
   logic          valid;
   logic          ready;
   logic [XW-1:0] x_value;
   logic          is_h_length;

   modport source (output valid, x_value, is_h_length, input ready);
   modport sink   (input valid, x_value, is_h_length, output ready);
endinterface

`default_nettype wire

FILE: design/gsff_rsp_if.sv
// Result channel of the form factor block: valid, ready and one result item.
// Depends on gsff_pkg.
`default_nettype none

interface gsff_rsp_if
   import gsff_pkg::*;
();
   logic           valid;
   logic           ready;
   logic [FfW-1:0] form_factor;
   logic           overflow;

   modport source (output valid, form_factor, overflow, input ready);
   modport sink   (input valid, form_factor, overflow, output ready);
endinterface

`default_nettype wire

FILE: design/gsff_csr_regs.sv
// Configuration registers: term count, coefficient pairs and offset.
// Depends on gsff_pkg.
`default_nettype none

module gsff_csr_regs
   import gsff_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [IdxW-1:0]  wr_index,
   input  wire logic [PairW-1:0] wr_data,
   output cfg_type               cfg
);

   logic [CntW-1:0]                 count_ff;
   logic [MaxTerms-1:0][PairW-1:0]  pair_ff;
   logic [CoefW-1:0]                offset_ff;
   logic [IdxW-1:0]                 pair_sel;

   assign pair_sel = wr_index - CsrPair0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pair_ff   <= '0;
         offset_ff <= '0;
      end else if (wr_en) begin
         priority if (wr_index == CsrTermCount) begin
            count_ff <= wr_data[CntW-1:0];
         end else if (wr_index >= CsrPair0 && wr_index < IdxW'(CsrPair0 + MaxTerms)) begin
            pair_ff[pair_sel] <= wr_data;
         end else if (wr_index == CsrOffset) begin
            offset_ff <= wr_data[CoefW-1:0];
         end
      end
   end

   always_comb begin
      cfg.n_terms = (count_ff > CntW'(MaxTerms)) ? CntW'(MaxTerms) : count_ff;
      for (int i = 0; i < MaxTerms; i++) begin
         cfg.a[i] = pair_ff[i][PairW-1:CoefW];
         cfg.b[i] = pair_ff[i][CoefW-1:0];
      end
      cfg.c = offset_ff;
   end

endmodule

`default_nettype wire

FILE: design/gsff_horner_step.sv
// One Horner step of the exponential series, two register stages:
// product with r, then exact division by the step constant. Depends on gsff_pkg.
`default_nettype none

module gsff_horner_step
   import gsff_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [NW-1:0]  n_step,
   input  lane_bus_type        bus_i,
   output lane_bus_type        bus_o
);

   lane_bus_type           mid_ff;
   logic [RW-1:0]          m_ff;
   logic [RW+PW-1:0]       rp_prod;
   logic [RW+PW-1:0]       q_prod;
   logic [RW-1:0]          q;
   lane_bus_type           out_in;
   lane_bus_type           out_ff;

   assign rp_prod = (RW+PW)'(bus_i.r) * (RW+PW)'(bus_i.p);
   assign q_prod  = (RW+PW)'(m_ff) * (RW+PW)'(recip_of(n_step));
   assign q       = RW'(q_prod >> shift_of(n_step));

   always_comb begin
      out_in   = mid_ff;
      out_in.p = OneQ32 - PW'(q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= bus_i;
         m_ff   <= rp_prod[2*RW-1:RW];
         out_ff <= out_in;
      end
   end

   assign bus_o = out_ff;

endmodule

`default_nettype wire

FILE: design/gsff_term_lane.sv
// One Gaussian term: exponent product, range reduction by ln 2, series,
// final shift and scaling by a. Depends on gsff_pkg and gsff_horner_step.
`default_nettype none

module gsff_term_lane
   import gsff_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [SqW-1:0]    sq,
   input  wire logic [CoefW-1:0]  coef_a,
   input  wire logic [CoefW-1:0]  coef_b,
   input  wire logic              active,
   output logic signed [FfW-1:0]  term
);

   logic [TW-1:0]                 t_ff;
   logic                          cut_ff [DivStages+1];
   logic [RemW-1:0]               rem_ff [DivStages+1];
   logic [KW-1:0]                 k_ff   [DivStages+1];
   lane_bus_type                  bus    [HornerDeg+1];
   logic [PW-1:0]                 e_ff;
   logic signed [FfW-1:0]         term_ff;
   logic signed [FfW+PW:0]        ae_prod;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= TW'(coef_b) * TW'(sq);
         cut_ff[0] <= (t_ff >= ExpCut);
         rem_ff[0] <= (t_ff >= ExpCut) ? '0 : t_ff[RemW+7:8];
         k_ff[0]   <= '0;
      end
   end

   for (genvar st = 0; st < DivStages; st++) begin : g_div
      logic [RemW-1:0] rem_in;
      logic [KW-1:0]   k_in;

      always_comb begin
         logic [RemW-1:0] d;
         int              jj;
         rem_in = rem_ff[st];
         k_in   = k_ff[st];
         for (int bi = 0; bi < DivBits; bi++) begin
            jj = KW - 1 - DivBits * st - bi;
            d  = RemW'(LnTwo) << jj;
            if (rem_in >= d) begin
               rem_in = rem_in - d;
               k_in   = k_in | (KW'(1) << jj);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cut_ff[st+1] <= cut_ff[st];
            rem_ff[st+1] <= rem_in;
            k_ff[st+1]   <= k_in;
         end
      end
   end

   always_comb begin
      bus[0].cut = cut_ff[DivStages];
      bus[0].k   = k_ff[DivStages];
      bus[0].r   = rem_ff[DivStages][RW-1:0];
      bus[0].p   = OneQ32;
   end

   for (genvar s = 0; s < HornerDeg; s++) begin : g_horner
      gsff_horner_step u_step (
         .clock  (clock),
         .en     (en),
         .n_step (NW'(HornerDeg - s)),
         .bus_i  (bus[s]),
         .bus_o  (bus[s+1])
      );
   end

   assign ae_prod = $signed(coef_a) * $signed({1'b0, e_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= bus[HornerDeg].cut ? '0 : (bus[HornerDeg].p >> bus[HornerDeg].k);
         term_ff <= active ? $signed(ae_prod[FfW+RW-1:RW]) : '0;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

FILE: design/gaussian_sum_form_factor.sv
// Gaussian-sum atomic form factor, f = sum a_i * exp(-b_i * s * s) + c.
// Depends on gsff_pkg, the channel interfaces, gsff_csr_regs and gsff_term_lane.
//
// Usage:
//   req_chan carries x_value (unsigned Q4.20) and is_h_length; an item is taken
//   when valid and ready are both high. rsp_chan returns form_factor (signed
//   Q12.20, saturated) and overflow, one result item per input item, in order.
//   The csr_ port writes term_count, the five coefficient pairs and offset_c;
//   write it only while no item is in flight.
//   Throughput is one item per cycle while the receiver does not stall; all term
//   lanes run in parallel and each series step is two multiplier stages, so the
//   depth is set by the twelve two-stage series steps of the exponential.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   req_chan.ready goes low in the same cycle; no item is lost or repeated.
//   Reset clears all valid bits and the configuration registers to zero.
`default_nettype none

module gaussian_sum_form_factor
   import gsff_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   gsff_req_if.sink              req_chan,
   gsff_rsp_if.source            rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [IdxW-1:0]  csr_index,
   input  wire logic [PairW-1:0] csr_wr_data
);

   cfg_type                       cfg;
   logic                          en;
   logic [PipeDepth-1:0]          vld_ff;
   logic [SqW-1:0]                sq_ff;
   logic [2*XW-1:0]               x_sq;
   logic signed [FfW-1:0]         term [MaxTerms];
   logic signed [SumW-1:0]        even_in, odd_in;
   logic signed [SumW-1:0]        even_ff, odd_ff, total_ff;
   logic [FfW-1:0]                ff_in, ff_ff;
   logic                          ovf_in, ovf_ff;
   logic [SumW-FfW:0]             top_bits;

   gsff_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wr_data),
      .cfg      (cfg)
   );

   assign en             = !vld_ff[PipeDepth-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign x_sq           = (2*XW)'(req_chan.x_value) * (2*XW)'(req_chan.x_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PipeDepth-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= req_chan.is_h_length ? SqW'(x_sq >> 22) : SqW'(x_sq >> 20);
      end
   end

   for (genvar i = 0; i < MaxTerms; i++) begin : g_lane
      gsff_term_lane u_lane (
         .clock  (clock),
         .en     (en),
         .sq     (sq_ff),
         .coef_a (cfg.a[i]),
         .coef_b (cfg.b[i]),
         .active (CntW'(i) < cfg.n_terms),
         .term   (term[i])
      );
   end

   always_comb begin
      even_in = SumW'($signed(cfg.c));
      odd_in  = '0;
      for (int i = 0; i < MaxTerms; i++) begin
         if (i % 2 == 0) begin
            even_in = even_in + SumW'(term[i]);
         end else begin
            odd_in = odd_in + SumW'(term[i]);
         end
      end
   end

   assign top_bits = total_ff[SumW-1:FfW-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         ff_in  = total_ff[FfW-1:0];
         ovf_in = 1'b0;
      end else begin
         ff_in  = total_ff[SumW-1] ? {1'b1, {(FfW-1){1'b0}}} : {1'b0, {(FfW-1){1'b1}}};
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         even_ff  <= even_in;
         odd_ff   <= odd_in;
         total_ff <= even_ff + odd_ff;
         ff_ff    <= ff_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_chan.valid       = vld_ff[PipeDepth-1];
   assign rsp_chan.form_factor = ff_ff;
   assign rsp_chan.overflow    = ovf_ff;

endmodule

`default_nettype wire

FILE: design/gsff_checker.sv
// Port-level checks of the form factor block and the bind that attaches them.
// Depends on gsff_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gsff_checker
   import gsff_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_ready,
   input wire logic           rsp_valid,
   input wire logic           rsp_ready,
   input wire logic [FfW-1:0] form_factor,
   input wire logic           overflow
);

   `GSFF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(form_factor) && $stable(overflow))

   `GSFF_ASSERT_SAME(a_sat_value, clock, reset, rsp_valid && overflow, form_factor == 32'h7FFF_FFFF || form_factor == 32'h8000_0000)

   `GSFF_ASSERT_SAME(a_ready_rule, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   `GSFF_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset), !rsp_valid)

endmodule

bind gaussian_sum_form_factor gsff_checker u_gsff_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .form_factor (rsp_chan.form_factor),
   .overflow    (rsp_chan.overflow)
);

`default_nettype wire

FILE: tb/form_factor_checker.sv
// Checker of the Gaussian-sum form factor block: watches the configuration
// port and both channels, predicts each result item and compares it.
// Depends on gsff_pkg and the channel interfaces.
`default_nettype none

module form_factor_checker
   import gsff_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   gsff_req_if                   req,
   gsff_rsp_if                   rsp,
   input  wire logic             csr_wr_en,
   input  wire logic [IdxW-1:0]  csr_index,
   input  wire logic [PairW-1:0] csr_wr_data,
   output int                    error_count,
   output int                    pending
);

   typedef struct packed {
      logic [FfW-1:0] form_factor;
      logic           overflow;
   } ff_result_type;

   localparam longint unsigned LnTwoQ32 = 64'hB17217F8;
   localparam longint unsigned OneQ32L  = 64'h1_0000_0000;
   localparam longint unsigned CutQ40   = 64'd23 << 40;

   logic [CntW-1:0]  n_terms;
   logic [PairW-1:0] pairs [MaxTerms];
   logic [CoefW-1:0] offset;
   ff_result_type    expected_results [$];

   function automatic longint unsigned decay_q32(input longint unsigned t);
      longint unsigned t32, k, r, p;
      if (t >= CutQ40) return 0;
      t32 = t >> 8;
      k = t32 / LnTwoQ32;
      r = t32 - k * LnTwoQ32;
      p = OneQ32L;
      for (int n = HornerDeg; n >= 1; n--) begin
         p = OneQ32L - (((r * p) >> 32) / longint'(n));
      end
      return p >> k;
   endfunction

   function automatic ff_result_type form_factor_of(input logic [XW-1:0] x, input logic h);
      longint unsigned sq, e;
      longint          sum, a;
      int              n;
      ff_result_type   res;
      sq = (longint'(x) * longint'(x)) >> (h ? 22 : 20);
      n = (n_terms > MaxTerms) ? MaxTerms : int'(n_terms);
      sum = longint'(signed'(offset));
      for (int i = 0; i < n; i++) begin
         a = longint'(signed'(pairs[i][PairW-1:CoefW]));
         e = decay_q32(longint'(pairs[i][CoefW-1:0]) * sq);
         sum += (a * longint'(e)) >>> 32;
      end
      res.overflow = 1'b0;
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         res.overflow = 1'b1;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         res.overflow = 1'b1;
      end
      res.form_factor = sum[FfW-1:0];
      return res;
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      ff_result_type want;
      if (reset) begin
         n_terms = '0;
         offset = '0;
         for (int i = 0; i < MaxTerms; i++) pairs[i] = '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected result item", 0, rsp.form_factor);
            end else begin
               want = expected_results.pop_front();
               if (rsp.form_factor !== want.form_factor)
                  report("form_factor", want.form_factor, rsp.form_factor);
               if (rsp.overflow !== want.overflow)
                  report("overflow", want.overflow, rsp.overflow);
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(form_factor_of(req.x_value, req.is_h_length));
         if (csr_wr_en) begin
            if (csr_index == CsrTermCount)
               n_terms = csr_wr_data[CntW-1:0];
            else if (csr_index == CsrOffset)
               offset = csr_wr_data[CoefW-1:0];
            else if (csr_index >= CsrPair0 && csr_index < CsrPair0 + MaxTerms)
               pairs[csr_index - CsrPair0] = csr_wr_data;
         end
      end
      pending = expected_results.size();
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Top of the form factor testbench: clock, reset, configuration phases and
// stimulus with random idling; gives the verdict. Depends on gsff_pkg, the
// channel interfaces, gaussian_sum_form_factor and form_factor_checker.
`default_nettype none

module testbench
   import gsff_pkg::*;
;
   localparam logic [IdxW-1:0] CsrUnused = 3'd7;
   localparam int SettleCycles = PipeDepth + 10;
   localparam int CycleLimit = 400000;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [IdxW-1:0]  csr_index;
   logic [PairW-1:0] csr_wr_data;
   int               error_count;
   int               pending;
   int               cycle_count;
   int               stall_left;
   bit               calm;

   gsff_req_if req ();
   gsff_rsp_if rsp ();

   gaussian_sum_form_factor u_dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   form_factor_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .error_count(error_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (calm || reset) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 12);
      end
      rsp.ready <= (stall_left == 0);
   end

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [PairW-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic send(input logic [XW-1:0] x, input logic h);
      @(negedge clock);
      req.valid <= 1'b1;
      req.x_value <= x;
      req.is_h_length <= h;
      do @(posedge clock); while (!req.ready);
      if (!calm && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
   endtask

   task automatic random_pairs(input int mode);
      logic [CoefW-1:0] a, b;
      for (int i = 0; i < MaxTerms; i++) begin
         a = $urandom;
         b = $urandom;
         if (mode == 1) b = $urandom_range(0, 1 << 22);
         if (mode == 2) a = a >>> $urandom_range(0, 8);
         write_reg(IdxW'(CsrPair0 + i), {a, b});
      end
   endtask

   function automatic logic [XW-1:0] random_x();
      logic [XW-1:0] x;
      x = XW'($urandom);
      if ($urandom_range(0, 2) == 0) x = x >> $urandom_range(1, 12);
      return x;
   endfunction

   initial begin
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.x_value = '0;
      req.is_h_length = 1'b0;
      rsp.ready = 1'b0;
      stall_left = 0;
      calm = 1'b0;
      cycle_count = 0;
      reset = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send(24'h000000, 1'b0);
      send(24'hFFFFFF, 1'b1);
      drain();

      write_reg(CsrTermCount, 64'd5);
      write_reg(IdxW'(CsrPair0 + 0), {32'h7FFFFFFF, 32'h00000000});
      write_reg(IdxW'(CsrPair0 + 1), {32'h80000000, 32'h00100000});
      write_reg(IdxW'(CsrPair0 + 2), {32'h00100000, 32'hFFFFFFFF});
      write_reg(IdxW'(CsrPair0 + 3), {32'hFFF00000, 32'h00040000});
      write_reg(IdxW'(CsrPair0 + 4), {32'h02000000, 32'h00008000});
      write_reg(CsrOffset, 64'h7FFFFFFF);
      write_reg(CsrUnused, 64'hFFFFFFFF_FFFFFFFF);
      send(24'h000000, 1'b0);
      send(24'hFFFFFF, 1'b0);
      send(24'hFFFFFF, 1'b1);
      send(24'h100000, 1'b0);
      send(24'h100000, 1'b1);
      send(24'h000001, 1'b0);
      drain();
      write_reg(CsrOffset, 64'h80000000);
      write_reg(CsrTermCount, 64'd7);
      send(24'h000000, 1'b0);
      send(24'h080000, 1'b1);
      drain();
      write_reg(CsrTermCount, 64'd0);
      send(24'h123456, 1'b0);
      send(24'hFFFFFF, 1'b1);
      drain();
      write_reg(CsrTermCount, 64'd6);
      write_reg(IdxW'(CsrPair0 + 0), 64'hFFFFFFFF_FFFFFFFF);
      write_reg(CsrOffset, 64'h0);
      send(24'h000000, 1'b1);
      send(24'hABCDEF, 1'b0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         calm = (phase == 7);
         write_reg(CsrTermCount, 64'($urandom_range(0, 7)));
         random_pairs(phase % 3);
         write_reg(CsrOffset, 64'($urandom));
         for (int i = 0; i < 155; i++) begin
            send(random_x(), 1'($urandom));
            if (phase == 3 && i == 70) begin
               @(negedge clock);
               req.valid <= 1'b0;
               while (pending != 0) @(negedge clock);
            end
         end
         @(negedge clock);
         req.valid <= 1'b0;
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
